@@ hw/rtl/mpct_pkg.sv @@
// shared types and constants for the mouse packet cursor tracker
package mpct_pkg;

    // configuration register layout
    localparam int LIMIT_W    = 13;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [LIMIT_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [LIMIT_W-1:0] HEIGHT_RESET = 13'd600;

    // cursor position after reset
    localparam logic [15:0] POS_X_RESET = 16'd5;
    localparam logic [15:0] POS_Y_RESET = 16'd2;

    // byte position within a packet
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PHASE_STATUS = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_DX     = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DY     = 2'd2;

    // status byte bit positions
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_MIDDLE = 2;
    localparam int BIT_X_OVF  = 6;
    localparam int BIT_Y_OVF  = 7;

    // screen limits as held by the configuration block
    typedef struct packed {
        logic [LIMIT_W-1:0] width;
        logic [LIMIT_W-1:0] height;
    } limits_t;

    // status flags carried to the result register
    typedef struct packed {
        logic y_ovf;
        logic x_ovf;
        logic middle;
        logic right;
        logic left;
    } flags_t;

endpackage

@@ hw/rtl/mouse_packet_cursor_tracker.sv @@
// top level: pointing-device packet decoder with clamped cursor tracking
// path: an accepted word passes through the input register, then the result register;
// throughput is one word per cycle while the result side keeps taking words
// the input register, when empty, takes a new word while a result waits to be taken
// reset: phase expects a status byte, status and x delta clear, cursor at (5, 2),
// screen limits 800 by 600
module mouse_packet_cursor_tracker #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mpct_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mpct_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // packet_byte[7:0]
    input  logic [7:0]                      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cursor_x, cursor_y, left_pressed, right_pressed, middle_pressed,
    // x_overflowed, y_overflowed, zero fill
    output logic [((2*COORD_WIDTH+12)/8)*8-1:0] m_axis_tdata,
    // packet_done
    output logic                            m_axis_tlast
);
    import mpct_pkg::*;

    localparam int FIELD_W = 2 * COORD_WIDTH + 5;
    localparam int OUT_W   = ((2 * COORD_WIDTH + 12) / 8) * 8;
    localparam int PAD_W   = OUT_W - FIELD_W;

    limits_t limits;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    // packet state
    logic [PHASE_W-1:0]     phase_reg,  phase_next;
    logic [7:0]             status_reg, status_next;
    logic [7:0]             dx_reg,     dx_next;
    logic [COORD_WIDTH-1:0] pos_x_reg,  pos_x_next;
    logic [COORD_WIDTH-1:0] pos_y_reg,  pos_y_next;
    logic                   done_next;

    logic [COORD_WIDTH-1:0] pos_x_moved;
    logic [COORD_WIDTH-1:0] pos_y_moved;
    logic signed [8:0]      delta_x;
    logic signed [8:0]      delta_y;

    // result register
    logic                   out_valid_reg;
    logic [COORD_WIDTH-1:0] out_x_reg;
    logic [COORD_WIDTH-1:0] out_y_reg;
    flags_t                 out_flags_reg;
    flags_t                 flags_next;
    logic                   out_done_reg;

    mpct_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .limits    (limits)
    );

    // handshake: the input register moves on whenever the result slot frees
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // deltas: x adds, y subtracts
    assign delta_x = $signed({dx_reg[7], dx_reg});
    assign delta_y = -$signed({in_byte_reg[7], in_byte_reg});

    mpct_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
        .pos     (pos_x_reg),
        .delta   (delta_x),
        .limit   (limits.width),
        .pos_new (pos_x_moved)
    );

    mpct_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
        .pos     (pos_y_reg),
        .delta   (delta_y),
        .limit   (limits.height),
        .pos_new (pos_y_moved)
    );

    // packet byte sequencing
    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        dx_next     = dx_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        done_next   = 1'b0;
        case (phase_reg)
            PHASE_DX:
            begin
                dx_next    = in_byte_reg;
                phase_next = PHASE_DY;
            end
            PHASE_DY:
            begin
                pos_x_next = pos_x_moved;
                pos_y_next = pos_y_moved;
                phase_next = PHASE_STATUS;
                done_next  = 1'b1;
            end
            default:
            begin
                status_next = in_byte_reg;
                phase_next  = PHASE_DX;
            end
        endcase
    end

    always_comb
    begin
        flags_next.left   = status_next[BIT_LEFT];
        flags_next.right  = status_next[BIT_RIGHT];
        flags_next.middle = status_next[BIT_MIDDLE];
        flags_next.x_ovf  = status_next[BIT_X_OVF];
        flags_next.y_ovf  = status_next[BIT_Y_OVF];
    end

    // state update on each word that moves into the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_STATUS;
            status_reg <= '0;
            dx_reg     <= '0;
            pos_x_reg  <= POS_X_RESET[COORD_WIDTH-1:0];
            pos_y_reg  <= POS_Y_RESET[COORD_WIDTH-1:0];
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            dx_reg     <= dx_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_x_reg     <= pos_x_next;
            out_y_reg     <= pos_y_next;
            out_flags_reg <= flags_next;
            out_done_reg  <= done_next;
        end
    end

    // output word packing, first field in the lowest bits
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}},
                            out_flags_reg.y_ovf,
                            out_flags_reg.x_ovf,
                            out_flags_reg.middle,
                            out_flags_reg.right,
                            out_flags_reg.left,
                            out_y_reg,
                            out_x_reg};

endmodule

@@ hw/rtl/mpct_cfg.sv @@
// configuration registers holding the screen limits
module mpct_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mpct_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mpct_pkg::LIMIT_W-1:0]    cfg_wdata,
    output mpct_pkg::limits_t               limits
);
    import mpct_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    // register write decode
    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SCREEN_WIDTH:  limits_next.width  = cfg_wdata;
                REG_SCREEN_HEIGHT: limits_next.height = cfg_wdata;
                default:           limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.width  <= WIDTH_RESET;
            limits_reg.height <= HEIGHT_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

@@ hw/rtl/mpct_axis.sv @@
// one cursor axis: add a signed delta and clamp to 0..limit-1, with the limit held to 1..full span
module mpct_axis #(
    parameter int COORD_WIDTH = 12
) (
    input  logic [COORD_WIDTH-1:0]       pos,
    input  logic signed [8:0]            delta,
    input  logic [mpct_pkg::LIMIT_W-1:0] limit,
    output logic [COORD_WIDTH-1:0]       pos_new
);
    import mpct_pkg::*;

    localparam int LW = (COORD_WIDTH + 1 > LIMIT_W) ? COORD_WIDTH + 1 : LIMIT_W;
    localparam int SW = COORD_WIDTH + 2;
    localparam logic [LW-1:0] SPAN = LW'(1) << COORD_WIDTH;

    logic [LW-1:0]          limit_ext;
    logic [LW-1:0]          limit_m1;
    logic [COORD_WIDTH-1:0] top;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   top_ext;

    // effective upper bound: zero acts as one, oversize acts as full span
    always_comb
    begin
        limit_ext = LW'(limit);
        limit_m1  = limit_ext - LW'(1);
        if (limit_ext == '0)
            top = '0;
        else if (limit_ext > SPAN)
            top = '1;
        else
            top = limit_m1[COORD_WIDTH-1:0];
    end

    // add and clamp
    always_comb
    begin
        sum     = $signed({2'b00, pos}) + SW'(delta);
        top_ext = $signed({2'b00, top});
        if (sum < 0)
            pos_new = '0;
        else if (sum > top_ext)
            pos_new = top;
        else
            pos_new = sum[COORD_WIDTH-1:0];
    end

endmodule

@@ tb/mouse_packet_cursor_tracker_tb.sv @@
// testbench for the mouse packet cursor tracker: directed and random packets checked against a cursor predictor
`timescale 1ns / 100ps

module mouse_packet_cursor_tracker_tb;
    import mpct_pkg::*;

    localparam int COORD_W     = 12;
    localparam int OUT_W       = ((2*COORD_W+12)/8)*8;
    localparam int HOLD_CYCLES = 64;

    // one result word as the block should deliver it
    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        flags_t             flags;
        logic               done;
    } cursor_word_t;

    // cursor predictor with its own copy of limits and packet state
    class cursor_predictor;
        logic [LIMIT_W-1:0] width_reg;
        logic [LIMIT_W-1:0] height_reg;
        logic [PHASE_W-1:0] phase;
        logic [7:0]         status_byte;
        logic [7:0]         dx_byte;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        cursor_word_t       awaited_words[$];
        int                 errors;

        function new();
            width_reg   = WIDTH_RESET;
            height_reg  = HEIGHT_RESET;
            phase       = PHASE_STATUS;
            status_byte = '0;
            dx_byte     = '0;
            pos_x       = POS_X_RESET[COORD_W-1:0];
            pos_y       = POS_Y_RESET[COORD_W-1:0];
            errors      = 0;
        endfunction

        function void set_limit(logic [CFG_ADDR_W-1:0] addr, logic [LIMIT_W-1:0] value);
            if (addr == REG_SCREEN_WIDTH)
                width_reg = value;
            else if (addr == REG_SCREEN_HEIGHT)
                height_reg = value;
        endfunction

        // zero acts as one, anything past the coordinate span acts as the span
        function int effective_limit(logic [LIMIT_W-1:0] r);
            if (r == 0)
                return 1;
            if (r > (1 << COORD_W))
                return 1 << COORD_W;
            return int'(r);
        endfunction

        function logic [COORD_W-1:0] clamp_axis(int v, int lim);
            if (v < 0)
                return '0;
            if (v > lim - 1)
                return COORD_W'(lim - 1);
            return COORD_W'(v);
        endfunction

        function void note_byte(logic [7:0] b);
            cursor_word_t w;
            w.done = 1'b0;
            case (phase)
                PHASE_DX:
                begin
                    dx_byte = b;
                    phase   = PHASE_DY;
                end
                PHASE_DY:
                begin
                    // y delta is positive upward, so the row index goes down
                    pos_x = clamp_axis(int'(pos_x) + int'($signed(dx_byte)),
                                       effective_limit(width_reg));
                    pos_y = clamp_axis(int'(pos_y) - int'($signed(b)),
                                       effective_limit(height_reg));
                    phase  = PHASE_STATUS;
                    w.done = 1'b1;
                end
                default:
                begin
                    status_byte = b;
                    phase       = PHASE_DX;
                end
            endcase
            w.x            = pos_x;
            w.y            = pos_y;
            w.flags.left   = status_byte[BIT_LEFT];
            w.flags.right  = status_byte[BIT_RIGHT];
            w.flags.middle = status_byte[BIT_MIDDLE];
            w.flags.x_ovf  = status_byte[BIT_X_OVF];
            w.flags.y_ovf  = status_byte[BIT_Y_OVF];
            awaited_words.push_back(w);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check_word(logic [OUT_W-1:0] data, logic last);
            cursor_word_t w;
            if (awaited_words.size() == 0)
            begin
                errors++;
                $display("%0t: word with nothing expected, expected none, actual %h",
                         $time, data);
                return;
            end
            w = awaited_words.pop_front();
            compare_field("cursor_x", w.x, data[COORD_W-1:0]);
            compare_field("cursor_y", w.y, data[2*COORD_W-1:COORD_W]);
            compare_field("left_pressed", w.flags.left, data[2*COORD_W]);
            compare_field("right_pressed", w.flags.right, data[2*COORD_W+1]);
            compare_field("middle_pressed", w.flags.middle, data[2*COORD_W+2]);
            compare_field("x_overflowed", w.flags.x_ovf, data[2*COORD_W+3]);
            compare_field("y_overflowed", w.flags.y_ovf, data[2*COORD_W+4]);
            compare_field("packet_done", w.done, last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [LIMIT_W-1:0]    cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;

    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit sink_hold = 1'b0;

    cursor_predictor cursor_pred;

    mouse_packet_cursor_tracker #(.COORD_WIDTH(COORD_W)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // offer one byte, with random gaps ahead of it, and note it once taken
    task automatic send_byte(logic [7:0] b);
        while (src_gaps && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cursor_pred.note_byte(b);
    endtask

    // stop offering and wait until every word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (cursor_pred.awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(logic [LIMIT_W-1:0] w, logic [LIMIT_W-1:0] h);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cursor_pred.set_limit(REG_SCREEN_WIDTH, w);
        cfg_addr  <= REG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cursor_pred.set_limit(REG_SCREEN_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_packet(logic [7:0] st, logic [7:0] dx, logic [7:0] dy);
        send_byte(st);
        send_byte(dx);
        send_byte(dy);
    endtask

    // delta byte, pushed toward one edge when drift is nonzero
    function automatic logic [7:0] step_byte(int drift, bit y_axis);
        int         r;
        logic [7:0] up;
        logic [7:0] down;
        r    = $urandom_range(99);
        up   = y_axis ? 8'h80 : 8'h7F;
        down = y_axis ? 8'h7F : 8'h80;
        if (drift != 0)
        begin
            if (r < 70)
                return (drift > 0) ? up : down;
            if (r < 80)
                return up;
            if (r < 90)
                return down;
        end
        else
        begin
            if (r < 15)
                return up;
            if (r < 30)
                return down;
        end
        return 8'($urandom_range(255));
    endfunction

    // new limits, then a run of bytes shaped by where the packet stands
    // the result side holds off once the limits are in, when asked
    task automatic run_phase(logic [LIMIT_W-1:0] w, logic [LIMIT_W-1:0] h,
                             int nbytes, int drift, bit hold_sink = 1'b0);
        logic [7:0] b;
        write_limits(w, h);
        if (hold_sink)
            sink_hold = 1'b1;
        repeat (nbytes)
        begin
            case (cursor_pred.phase)
                PHASE_DX: b = step_byte(drift, 1'b0);
                PHASE_DY: b = step_byte(drift, 1'b1);
                default:  b = 8'($urandom_range(255));
            endcase
            send_byte(b);
        end
    endtask

    // result side: random ready, one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                cursor_pred.check_word(m_axis_tdata, m_axis_tlast);
            if (sink_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            else
                m_axis_tready <= !(sink_gaps && $urandom_range(99) < 38);
        end
    end

    // main sequence
    initial
    begin
        cursor_pred = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all decoded status bits, only the undecoded status bits, full-scale deltas
        send_packet(8'hC7, 8'h7F, 8'h80);
        send_packet(8'h38, 8'h80, 8'h7F);
        send_packet(8'h01, 8'h7F, 8'h80);
        // limits change mid-packet and apply only at completion; zero acts as one
        send_byte(8'h02);
        send_byte(8'h40);
        write_limits(13'd0, 13'd1);
        send_byte(8'h00);
        send_packet(8'hFF, 8'hFF, 8'h00);
        // limits past the coordinate span
        write_limits(13'd8191, 13'd4097);
        send_packet(8'h40, 8'h7F, 8'h80);
        send_packet(8'h80, 8'h80, 8'h7F);

        // random phases over several limit settings
        run_phase(13'd4096, 13'd4096, 210, 1);
        run_phase(13'd8191, 13'd4097, 90, -1);
        run_phase(13'd0, 13'd1, 60, 1);
        run_phase(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)), 90, 0, 1'b1);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_phase(WIDTH_RESET, HEIGHT_RESET, 90, 1);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        run_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 90, -1);

        wait_drained();
        repeat (10) @(posedge clk);
        if (cursor_pred.errors == 0 && cursor_pred.awaited_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mpct_pkg.sv
hw/rtl/mpct_cfg.sv
hw/rtl/mpct_axis.sv
hw/rtl/mouse_packet_cursor_tracker.sv
tb/mouse_packet_cursor_tracker_tb.sv
